// File: sv/pinned_lru_cache_manager_top_assert.svh
// Assertion macros for the pinned LRU cache manager.
`ifndef PINNED_LRU_CACHE_MANAGER_TOP_ASSERT_SVH
`define PINNED_LRU_CACHE_MANAGER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLCM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plcm assertion failed");
`define PLCM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plcm assertion failed");
`else
`define PLCM_ASSERT_IMPL(name, ante, cons)
`define PLCM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: sv/plcm_pkg.sv
// Package with command, status and register codes of the cache manager.
`timescale 1ns / 1ps
`default_nettype none
package plcm_pkg;
  localparam int CMD_W     = 3;
  localparam int ID_W      = 16;
  localparam int BYTES_W   = 40;
  localparam int REFS_W    = 8;
  localparam int STAMP_W   = 48;
  localparam int CNT_OUT_W = 4;
  localparam int TOTAL_W   = 44;
  localparam int STAT_W    = 3;
  localparam int CTR_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PRELOAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNLOAD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TRIM    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_IN_USE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_EVICT  = 2'd2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [REFS_W-1:0]  REFS_MAX  = {REFS_W{1'b1}};
endpackage
`default_nettype wire

// File: sv/plcm_if.sv
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface plcm_in_if import plcm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ID_W-1:0]      model_id;
  logic [BYTES_W-1:0]   size_bytes;
  logic                 load_ok;
  modport source (output valid, cmd, model_id, size_bytes, load_ok, input ready);
  modport sink (input valid, cmd, model_id, size_bytes, load_ok, output ready);
endinterface

interface plcm_out_if import plcm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic                 was_hit;
  logic [CNT_OUT_W-1:0] resident_count;
  logic [TOTAL_W-1:0]   total_bytes;
  logic [REFS_W-1:0]    entry_refs;
  logic [BYTES_W-1:0]   entry_bytes;
  logic [CTR_W-1:0]     hit_total;
  logic [CTR_W-1:0]     miss_total;
  modport source (output valid, status, was_hit, resident_count, total_bytes, entry_refs,
                  entry_bytes, hit_total, miss_total, input ready);
  modport sink (input valid, status, was_hit, resident_count, total_bytes, entry_refs,
                entry_bytes, hit_total, miss_total, output ready);
endinterface
`default_nettype wire

// File: sv/plcm_entry_ram.sv
// Slot table memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module plcm_entry_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 112
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/pinned_lru_cache_manager_top.sv
// Pinned LRU cache manager: slot table in memory, scanned one slot per cycle.
// Each command scans the table, applies its change, then scans it again for the report;
// each eviction it makes adds one more scan. The next command is accepted only after
// the result is loaded into the output register; items are handled one at a time.
// Reset (synchronous, rst_n low) clears valid bits, stamp, counters and limits; auto-evict resets to 1.
`timescale 1ns / 1ps
`default_nettype none
module pinned_lru_cache_manager_top import plcm_pkg::*; #(
  parameter int SLOTS    = 8,
  parameter int KEY_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [TOTAL_W-1:0]   cfg_wdata,
  plcm_in_if.sink                   in_ch,
  plcm_out_if.source                out_ch
);
  `include "pinned_lru_cache_manager_top_assert.svh"

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SUM_W = TOTAL_W + CNT_W;
  localparam int LIM_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int ENT_W = KEY_BITS + BYTES_W + REFS_W + STAMP_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [CNT_OUT_W-1:0] max_entries_r;
  logic [TOTAL_W-1:0]   max_bytes_r;
  logic                 auto_evict_r;

  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [CTR_W-1:0]   hit_cnt_r, hit_cnt_nxt, miss_cnt_r, miss_cnt_nxt;

  logic [CMD_W-1:0]    q_cmd_r;
  logic [KEY_BITS-1:0] q_key_r;
  logic [BYTES_W-1:0]  q_size_r;
  logic                q_ok_r;
  logic [STAT_W-1:0]   q_status_r, q_status_nxt;
  logic                q_hit_r, q_hit_nxt;
  logic                rep_r, rep_nxt, ld_r, ld_nxt, ph_r, ph_nxt;

  logic [IDX_W-1:0] sc_idx_r, sc_idx_nxt, p_idx_r;
  logic             p_vld_r, p_vld_nxt;

  logic [CNT_W-1:0]   acc_cnt_r, acc_cnt_nxt;
  logic [SUM_W-1:0]   acc_sum_r, acc_sum_nxt;
  logic               acc_hit_r, acc_hit_nxt;
  logic [IDX_W-1:0]   acc_hidx_r, acc_hidx_nxt;
  logic [REFS_W-1:0]  acc_hrefs_r, acc_hrefs_nxt;
  logic [BYTES_W-1:0] acc_hbytes_r, acc_hbytes_nxt;
  logic               acc_lru_r, acc_lru_nxt;
  logic [IDX_W-1:0]   acc_lidx_r, acc_lidx_nxt;
  logic [STAMP_W-1:0] acc_lstamp_r, acc_lstamp_nxt;
  logic [SLOTS-1:0]   clr_mask_r, clr_mask_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r;
  logic                 out_hit_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic [REFS_W-1:0]    out_refs_r;
  logic [BYTES_W-1:0]   out_bytes_r;
  logic [CTR_W-1:0]     out_hits_r, out_misses_r;
  logic                 out_load;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;

  logic [KEY_BITS-1:0] rd_key;
  logic [BYTES_W-1:0]  rd_bytes;
  logic [REFS_W-1:0]   rd_refs;
  logic [STAMP_W-1:0]  rd_stamp;
  logic                rd_vld;

  logic [KEY_BITS+ID_W-1:0] key_ext;
  logic                     in_xfer, out_xfer, start_scan;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [LIM_W-1:0]         me_ext, cnt_l, lim;
  logic [SUM_W:0]           sum_plus, mb_ext;
  logic                     need_evict, over_b, over_e;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;
  logic [STAMP_W-1:0]       stamp_inc;

  plcm_entry_ram #(.DEPTH(SLOTS), .WIDTH(ENT_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key   = mem_rdata[ENT_W-1 -: KEY_BITS];
  assign rd_bytes = mem_rdata[BYTES_W+REFS_W+STAMP_W-1 -: BYTES_W];
  assign rd_refs  = mem_rdata[REFS_W+STAMP_W-1 -: REFS_W];
  assign rd_stamp = mem_rdata[STAMP_W-1:0];
  assign rd_vld   = p_vld_r && valid_r[p_idx_r];

  assign key_ext  = (KEY_BITS + ID_W)'(in_ch.model_id);
  assign in_ch.ready = (st_r == S_IDLE);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign stamp_inc = stamp_r + STAMP_W'(1);

  assign me_ext   = LIM_W'(max_entries_r);
  assign cnt_l    = LIM_W'(acc_cnt_r);
  assign lim      = (me_ext != '0 && me_ext < LIM_W'(SLOTS)) ? me_ext : LIM_W'(SLOTS);
  assign sum_plus = (SUM_W + 1)'(acc_sum_r) + (SUM_W + 1)'(q_size_r);
  assign mb_ext   = (SUM_W + 1)'(max_bytes_r);
  assign need_evict = (cnt_l >= lim) || (max_bytes_r != '0 && sum_plus > mb_ext);
  assign over_b   = (max_bytes_r != '0) && (acc_sum_r > SUM_W'(max_bytes_r));
  assign over_e   = (max_entries_r != '0) && (cnt_l > me_ext);
  assign cnt_wide = (CNT_W + CNT_OUT_W)'(acc_cnt_r);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    st_nxt       = st_r;
    valid_nxt    = valid_r;
    stamp_nxt    = stamp_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    q_status_nxt = q_status_r;
    q_hit_nxt    = q_hit_r;
    rep_nxt      = rep_r;
    ld_nxt       = ld_r;
    ph_nxt       = ph_r;
    sc_idx_nxt   = sc_idx_r;
    p_vld_nxt    = 1'b0;
    mem_raddr    = sc_idx_r;
    mem_we       = 1'b0;
    mem_waddr    = acc_hidx_r;
    mem_wdata    = {q_key_r, acc_hbytes_r, acc_hrefs_r, stamp_inc};
    start_scan   = 1'b0;
    out_load     = 1'b0;

    acc_cnt_nxt    = acc_cnt_r;
    acc_sum_nxt    = acc_sum_r;
    acc_hit_nxt    = acc_hit_r;
    acc_hidx_nxt   = acc_hidx_r;
    acc_hrefs_nxt  = acc_hrefs_r;
    acc_hbytes_nxt = acc_hbytes_r;
    acc_lru_nxt    = acc_lru_r;
    acc_lidx_nxt   = acc_lidx_r;
    acc_lstamp_nxt = acc_lstamp_r;
    clr_mask_nxt   = clr_mask_r;

    if (rd_vld) begin
      acc_cnt_nxt = acc_cnt_r + CNT_W'(1);
      acc_sum_nxt = acc_sum_r + SUM_W'(rd_bytes);
      if (!acc_hit_r && rd_key == q_key_r) begin
        acc_hit_nxt    = 1'b1;
        acc_hidx_nxt   = p_idx_r;
        acc_hrefs_nxt  = rd_refs;
        acc_hbytes_nxt = rd_bytes;
      end
      if (rd_refs == '0) begin
        clr_mask_nxt[p_idx_r] = 1'b1;
        if (!acc_lru_r || rd_stamp < acc_lstamp_r) begin
          acc_lru_nxt    = 1'b1;
          acc_lidx_nxt   = p_idx_r;
          acc_lstamp_nxt = rd_stamp;
        end
      end
    end

    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          q_status_nxt = ST_OK;
          q_hit_nxt    = 1'b0;
          rep_nxt      = 1'b0;
          ld_nxt       = 1'b0;
          ph_nxt       = 1'b0;
          start_scan   = 1'b1;
        end
      end
      S_SCAN: begin
        p_vld_nxt = 1'b1;
        if (sc_idx_r == IDX_W'(SLOTS - 1)) begin
          st_nxt = S_DRAIN;
        end else begin
          sc_idx_nxt = sc_idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        st_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (rep_r) begin
          if (!out_valid_r || out_ch.ready) begin
            out_load = 1'b1;
            st_nxt   = S_IDLE;
          end
        end else begin
          rep_nxt    = 1'b1;
          start_scan = 1'b1;
          case (q_cmd_r)
            CMD_ACQUIRE, CMD_PRELOAD: begin
              if (!ld_r && acc_hit_r) begin
                if (q_cmd_r == CMD_ACQUIRE) begin
                  q_hit_nxt   = 1'b1;
                  hit_cnt_nxt = hit_cnt_r + CTR_W'(1);
                  stamp_nxt   = stamp_inc;
                  mem_we      = 1'b1;
                  mem_wdata   = {q_key_r, acc_hbytes_r,
                                 (acc_hrefs_r == REFS_MAX) ? acc_hrefs_r
                                                           : acc_hrefs_r + REFS_W'(1),
                                 stamp_inc};
                end
              end else begin
                if (!ld_r && q_cmd_r == CMD_ACQUIRE) begin
                  miss_cnt_nxt = miss_cnt_r + CTR_W'(1);
                end
                if (!q_ok_r) begin
                  q_status_nxt = ST_INVALID;
                end else if (auto_evict_r && need_evict) begin
                  if (acc_lru_r) begin
                    valid_nxt[acc_lidx_r] = 1'b0;
                    ld_nxt  = 1'b1;
                    rep_nxt = 1'b0;
                  end else begin
                    q_status_nxt = ST_FULL;
                  end
                end else if (free_found) begin
                  valid_nxt[free_idx] = 1'b1;
                  stamp_nxt = stamp_inc;
                  mem_we    = 1'b1;
                  mem_waddr = free_idx;
                  mem_wdata = {q_key_r, q_size_r,
                               (q_cmd_r == CMD_ACQUIRE) ? REFS_W'(1) : REFS_W'(0),
                               stamp_inc};
                end else begin
                  q_status_nxt = ST_FULL;
                end
              end
            end
            CMD_RELEASE: begin
              if (!acc_hit_r) begin
                q_status_nxt = ST_NOT_FOUND;
              end else begin
                stamp_nxt = stamp_inc;
                mem_we    = 1'b1;
                mem_wdata = {q_key_r, acc_hbytes_r,
                             (acc_hrefs_r == '0) ? acc_hrefs_r : acc_hrefs_r - REFS_W'(1),
                             stamp_inc};
              end
            end
            CMD_UNLOAD: begin
              if (!acc_hit_r) begin
                q_status_nxt = ST_NOT_FOUND;
              end else if (acc_hrefs_r != '0) begin
                q_status_nxt = ST_IN_USE;
              end else begin
                valid_nxt[acc_hidx_r] = 1'b0;
              end
            end
            CMD_CLEAR: begin
              valid_nxt = valid_r & ~clr_mask_r;
            end
            CMD_TRIM: begin
              if (!ph_r && over_b && acc_lru_r) begin
                valid_nxt[acc_lidx_r] = 1'b0;
                rep_nxt = 1'b0;
              end else if (over_e && acc_lru_r) begin
                valid_nxt[acc_lidx_r] = 1'b0;
                ph_nxt  = 1'b1;
                rep_nxt = 1'b0;
              end else begin
                q_status_nxt = (over_b || over_e) ? ST_FULL : ST_OK;
              end
            end
            default: begin
              if (!acc_hit_r) begin
                q_status_nxt = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (start_scan) begin
      st_nxt         = S_SCAN;
      sc_idx_nxt     = '0;
      acc_cnt_nxt    = '0;
      acc_sum_nxt    = '0;
      acc_hit_nxt    = 1'b0;
      acc_lru_nxt    = 1'b0;
      clr_mask_nxt   = '0;
    end

    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      max_entries_r <= '0;
      max_bytes_r   <= '0;
      auto_evict_r  <= 1'b1;
      valid_r       <= '0;
      stamp_r       <= '0;
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      p_vld_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      stamp_r     <= stamp_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          REG_MAX_ENTRIES: max_entries_r <= cfg_wdata[CNT_OUT_W-1:0];
          REG_MAX_BYTES:   max_bytes_r   <= cfg_wdata;
          REG_AUTO_EVICT:  auto_evict_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      q_cmd_r  <= in_ch.cmd;
      q_key_r  <= key_ext[KEY_BITS-1:0];
      q_size_r <= in_ch.size_bytes;
      q_ok_r   <= in_ch.load_ok;
    end
    q_status_r   <= q_status_nxt;
    q_hit_r      <= q_hit_nxt;
    rep_r        <= rep_nxt;
    ld_r         <= ld_nxt;
    ph_r         <= ph_nxt;
    sc_idx_r     <= sc_idx_nxt;
    p_idx_r      <= sc_idx_r;
    acc_cnt_r    <= acc_cnt_nxt;
    acc_sum_r    <= acc_sum_nxt;
    acc_hit_r    <= acc_hit_nxt;
    acc_hidx_r   <= acc_hidx_nxt;
    acc_hrefs_r  <= acc_hrefs_nxt;
    acc_hbytes_r <= acc_hbytes_nxt;
    acc_lru_r    <= acc_lru_nxt;
    acc_lidx_r   <= acc_lidx_nxt;
    acc_lstamp_r <= acc_lstamp_nxt;
    clr_mask_r   <= clr_mask_nxt;
    if (out_load) begin
      out_status_r <= q_status_r;
      out_hit_r    <= q_hit_r;
      out_cnt_r    <= cnt_wide[CNT_OUT_W-1:0];
      out_total_r  <= (acc_sum_r > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : acc_sum_r[TOTAL_W-1:0];
      out_refs_r   <= acc_hit_r ? acc_hrefs_r : '0;
      out_bytes_r  <= acc_hit_r ? acc_hbytes_r : '0;
      out_hits_r   <= hit_cnt_r;
      out_misses_r <= miss_cnt_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.was_hit        = out_hit_r;
  assign out_ch.resident_count = out_cnt_r;
  assign out_ch.total_bytes    = out_total_r;
  assign out_ch.entry_refs     = out_refs_r;
  assign out_ch.entry_bytes    = out_bytes_r;
  assign out_ch.hit_total      = out_hits_r;
  assign out_ch.miss_total     = out_misses_r;

  `PLCM_ASSERT_IMPL(a_write_only_in_eval, mem_we, st_r == S_EVAL && !rep_r)
  `PLCM_ASSERT_NEXT(a_accept_starts_scan, in_xfer, st_r == S_SCAN && sc_idx_r == '0)
  `PLCM_ASSERT_IMPL(a_hit_means_ok, out_valid_r && out_hit_r, out_status_r == ST_OK)
  `PLCM_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_r && st_r == S_IDLE)
endmodule
`default_nettype wire
